[hw/rtl/integer_literal_parser_unit_macros.svh]
// Assertion helpers; every user names its clock clk and its reset rst_n.
`ifndef INTEGER_LITERAL_PARSER_UNIT_MACROS_SVH
`define INTEGER_LITERAL_PARSER_UNIT_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define ILP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define ILP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/ilp_pkg.sv]
`default_nettype none

package ilp_pkg;

  localparam int CHAR_W = 8;
  localparam int MAG_W  = 64;

  localparam logic [MAG_W-1:0] NEG_LIMIT = 64'h8000_0000_0000_0000;

  localparam logic [CHAR_W-1:0] CH_NUL        = 8'h00;
  localparam logic [CHAR_W-1:0] CH_MINUS      = 8'h2d;
  localparam logic [CHAR_W-1:0] CH_ZERO       = 8'h30;
  localparam logic [CHAR_W-1:0] CH_ONE        = 8'h31;
  localparam logic [CHAR_W-1:0] CH_SEVEN      = 8'h37;
  localparam logic [CHAR_W-1:0] CH_NINE       = 8'h39;
  localparam logic [CHAR_W-1:0] CH_UNDERSCORE = 8'h5f;
  localparam logic [CHAR_W-1:0] CH_B          = 8'h62;
  localparam logic [CHAR_W-1:0] CH_X          = 8'h78;

  typedef enum logic [1:0] {
    RX_DEC = 2'd0,
    RX_OCT = 2'd1,
    RX_BIN = 2'd2,
    RX_HEX = 2'd3
  } radix_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } digit_t;

  function automatic logic is_letter(logic [CHAR_W-1:0] c);
    return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
  endfunction

  function automatic logic is_punct(logic [CHAR_W-1:0] c);
    return (c >= 8'h21 && c <= 8'h2f) || (c >= 8'h3a && c <= 8'h40) ||
           (c >= 8'h5b && c <= 8'h60) || (c >= 8'h7b && c <= 8'h7e);
  endfunction

  function automatic digit_t digit_of(logic [CHAR_W-1:0] c, radix_t rx);
    digit_t d;
    d.ok  = 1'b0;
    d.val = c[3:0];
    case (rx)
      RX_HEX: begin
        if (c >= CH_ZERO && c <= CH_NINE) begin
          d.ok = 1'b1;
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
          // low nibble of 'a'/'A' is 1, so +9 gives 10
          d.ok  = 1'b1;
          d.val = c[3:0] + 4'd9;
        end
      end
      RX_BIN:  d.ok = (c == CH_ZERO) || (c == CH_ONE);
      RX_OCT:  d.ok = (c >= CH_ZERO) && (c <= CH_SEVEN);
      default: d.ok = (c >= CH_ZERO) && (c <= CH_NINE);
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/ilp_if.sv]
`default_nettype none

interface ilp_in_if;
  import ilp_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] character;

  modport source (output valid, output character, input ready);
  modport sink (input valid, input character, output ready);
endinterface

interface ilp_out_if;
  import ilp_pkg::*;

  logic             valid;
  logic             ready;
  logic             valid_res;
  logic             is_negative;
  logic [MAG_W-1:0] magnitude;

  modport source (output valid, output valid_res, output is_negative, output magnitude,
                  input ready);
  modport sink (input valid, input valid_res, input is_negative, input magnitude,
                output ready);
endinterface

`default_nettype wire

[hw/rtl/integer_literal_parser_unit.sv]
// Streaming integer-literal parser. One ASCII character is taken per request on in_ch
// and at most one result leaves on out_ch per literal, when its terminating character
// is seen. The block sustains one character per cycle, stalls apart: each character is
// captured in an input register, and from there a single pass of logic (digit decode
// plus the 68-bit multiply-by-radix-and-add that also yields exact overflow) updates
// the parser state and, for a terminator, loads the result register. A result thus
// passes through the input register and then the result register before it is visible
// on out_ch. The input side only stalls while a terminator is waiting behind a result
// that has not yet been taken.
`default_nettype none

module integer_literal_parser_unit (
  input  wire         clk,
  input  wire         rst_n,
  ilp_in_if.sink      in_ch,
  ilp_out_if.source   out_ch
);
  import ilp_pkg::*;

  `include "integer_literal_parser_unit_macros.svh"

  typedef enum logic [1:0] {
    PH_START  = 2'd0,
    PH_ZERO   = 2'd1,
    PH_DIGITS = 2'd2
  } phase_t;

  localparam int WIDE_W = MAG_W + 4;

  // input stage
  logic              in_valid_r;
  logic [CHAR_W-1:0] char_r;

  // parser state
  phase_t           phase_r, phase_nxt;
  radix_t           radix_r, radix_nxt;
  logic [MAG_W-1:0] acc_r, acc_nxt;
  logic             digit_seen_r, digit_seen_nxt;
  logic             sign_r, sign_nxt;
  logic             ovf_r, ovf_nxt;

  // result stage
  logic             out_valid_r;
  logic             res_ok_r;
  logic             res_neg_r;
  logic [MAG_W-1:0] res_mag_r;

  logic             emit;
  logic             emit_ok;
  logic [MAG_W-1:0] emit_mag;
  logic             do_acc;
  radix_t           acc_rx;
  digit_t           dig;
  logic [WIDE_W-1:0] scaled;
  logic [WIDE_W-1:0] wide;
  logic             advance;
  logic             fire;
  logic             in_ready;

  // radix used by the digit decode depends on where we are in the literal
  always_comb begin
    case (phase_r)
      PH_ZERO:   acc_rx = RX_OCT;
      PH_DIGITS: acc_rx = radix_r;
      default:   acc_rx = RX_DEC;
    endcase
    dig = digit_of(char_r, acc_rx);
    case (acc_rx)
      RX_HEX:  scaled = {acc_r, 4'b0000};
      RX_OCT:  scaled = {1'b0, acc_r, 3'b000};
      RX_BIN:  scaled = {3'b000, acc_r, 1'b0};
      default: scaled = {1'b0, acc_r, 3'b000} + {3'b000, acc_r, 1'b0};
    endcase
    wide = scaled + {{(WIDE_W-4){1'b0}}, dig.val};
  end

  always_comb begin
    phase_nxt      = phase_r;
    radix_nxt      = radix_r;
    acc_nxt        = acc_r;
    digit_seen_nxt = digit_seen_r;
    sign_nxt       = sign_r;
    ovf_nxt        = ovf_r;
    emit           = 1'b0;
    emit_ok        = 1'b0;
    emit_mag       = '0;
    do_acc         = 1'b0;

    case (phase_r)
      PH_ZERO: begin
        if (char_r >= CH_ZERO && char_r <= CH_NINE) begin
          radix_nxt = RX_OCT;
          phase_nxt = PH_DIGITS;
          if (dig.ok) begin
            do_acc = 1'b1;
          end else begin
            emit = 1'b1;
          end
        end else if (char_r == CH_B) begin
          radix_nxt = RX_BIN;
          phase_nxt = PH_DIGITS;
        end else if (char_r == CH_X) begin
          radix_nxt = RX_HEX;
          phase_nxt = PH_DIGITS;
        end else begin
          // bare zero is closed by punctuation (not underscore) or NUL
          emit    = 1'b1;
          emit_ok = (is_punct(char_r) && char_r != CH_UNDERSCORE) || char_r == CH_NUL;
        end
      end
      PH_DIGITS: begin
        if (dig.ok) begin
          do_acc = 1'b1;
        end else begin
          emit     = 1'b1;
          emit_ok  = !is_letter(char_r) && digit_seen_r && !ovf_r &&
                     !(sign_r && acc_r > NEG_LIMIT);
          emit_mag = acc_r;
        end
      end
      default: begin
        if (char_r == CH_MINUS && !sign_r) begin
          sign_nxt = 1'b1;
        end else if (char_r == CH_ZERO) begin
          phase_nxt = PH_ZERO;
        end else if (char_r >= CH_ONE && char_r <= CH_NINE) begin
          radix_nxt = RX_DEC;
          phase_nxt = PH_DIGITS;
          do_acc    = 1'b1;
        end else begin
          emit = 1'b1;
        end
      end
    endcase

    if (do_acc) begin
      digit_seen_nxt = 1'b1;
      if (!ovf_r) begin
        if (|wide[WIDE_W-1:MAG_W]) begin
          ovf_nxt = 1'b1;
        end else begin
          acc_nxt = wide[MAG_W-1:0];
        end
      end
    end

    if (emit) begin
      phase_nxt      = PH_START;
      radix_nxt      = RX_DEC;
      acc_nxt        = '0;
      digit_seen_nxt = 1'b0;
      sign_nxt       = 1'b0;
      ovf_nxt        = 1'b0;
    end
  end

  // only a terminator needs room in the result register
  assign advance  = !emit || !out_valid_r || out_ch.ready;
  assign fire     = in_valid_r && advance;
  assign in_ready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r   <= 1'b0;
      char_r       <= '0;
      phase_r      <= PH_START;
      radix_r      <= RX_DEC;
      acc_r        <= '0;
      digit_seen_r <= 1'b0;
      sign_r       <= 1'b0;
      ovf_r        <= 1'b0;
      out_valid_r  <= 1'b0;
      res_ok_r     <= 1'b0;
      res_neg_r    <= 1'b0;
      res_mag_r    <= '0;
    end else begin
      if (in_ready) begin
        in_valid_r <= in_ch.valid;
      end
      if (in_ready && in_ch.valid) begin
        char_r <= in_ch.character;
      end
      if (fire) begin
        phase_r      <= phase_nxt;
        radix_r      <= radix_nxt;
        acc_r        <= acc_nxt;
        digit_seen_r <= digit_seen_nxt;
        sign_r       <= sign_nxt;
        ovf_r        <= ovf_nxt;
      end
      if (fire && emit) begin
        out_valid_r <= 1'b1;
        res_ok_r    <= emit_ok;
        res_neg_r   <= sign_r;
        res_mag_r   <= emit_ok ? emit_mag : '0;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign in_ch.ready        = in_ready;
  assign out_ch.valid       = out_valid_r;
  assign out_ch.valid_res   = res_ok_r;
  assign out_ch.is_negative = res_neg_r;
  assign out_ch.magnitude   = res_mag_r;

  `ILP_ASSERT_NOW(a_invalid_zero_mag, out_valid_r && !res_ok_r, res_mag_r == '0,
                  "invalid result carries a nonzero magnitude")
  `ILP_ASSERT_NOW(a_neg_in_range, out_valid_r && res_ok_r && res_neg_r,
                  res_mag_r <= NEG_LIMIT, "negative result beyond 2^63")
  `ILP_ASSERT_NOW(a_ovf_has_digit, ovf_r, digit_seen_r,
                  "overflow flagged with no digit seen")
  `ILP_ASSERT_NEXT(a_restart_after_emit, fire && emit,
                   phase_r == PH_START && !sign_r && acc_r == '0 && !ovf_r && out_valid_r,
                   "parser did not restart after a result")

endmodule

`default_nettype wire
